// ----- rtl/core/sdq_pkg.sv -----
// Package for the searchable deque: sizes, command and status codes, and the
// word types that travel on the ports and between the front and back parts.
// Depends on nothing.
package sdq_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int LEN_BITS   = $clog2(DEPTH + 1);

    localparam int CMD_W      = 3;
    localparam int ITEM_W     = 32;
    localparam int INDEX_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int LENGTH_W   = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ITEM_W-1:0] item_value;
    } in_word_t;

    typedef struct packed {
        logic [ITEM_W-1:0]   out_value;
        logic [INDEX_W-1:0]  found_index;
        logic [STATUS_W-1:0] status;
        logic [LENGTH_W-1:0] new_length;
    } out_word_t;

    typedef struct packed {
        logic                  add;
        logic                  take;
        logic                  at_front;
        logic                  search;
        logic                  remove_match;
        logic [VALUE_BITS-1:0] value;
    } op_t;

endpackage

// ----- rtl/core/sdq_front.sv -----
// Front part of the searchable deque: accepts input words, decodes the
// command into an operation and holds it in a two-slot queue for the back.
// Depends on sdq_pkg.
module sdq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  sdq_pkg::in_word_t item,
    output logic              op_valid,
    input  logic              op_take,
    output sdq_pkg::op_t      op
);

    sdq_pkg::op_t slot_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    logic         wr_en;
    logic         rd_en;
    sdq_pkg::op_t decoded;

    always_comb
    begin
        decoded       = '0;
        decoded.value = item.item_value[sdq_pkg::VALUE_BITS-1:0];
        unique case (item.command)
            sdq_pkg::CMD_PUSH_BACK:
            begin
                decoded.add = 1'b1;
            end
            sdq_pkg::CMD_PUSH_FRONT:
            begin
                decoded.add      = 1'b1;
                decoded.at_front = 1'b1;
            end
            sdq_pkg::CMD_POP_BACK:
            begin
                decoded.take = 1'b1;
            end
            sdq_pkg::CMD_POP_FRONT:
            begin
                decoded.take     = 1'b1;
                decoded.at_front = 1'b1;
            end
            sdq_pkg::CMD_FIND:
            begin
                decoded.search = 1'b1;
            end
            sdq_pkg::CMD_DELETE:
            begin
                decoded.search       = 1'b1;
                decoded.remove_match = 1'b1;
            end
            default:
            begin
                decoded.add = 1'b0;
            end
        endcase
    end

    assign full     = (cnt_reg == 2'd2);
    assign op_valid = (cnt_reg != 2'd0);
    assign op       = slot_reg[rd_ptr_reg];
    assign wr_en    = push && !full;
    assign rd_en    = op_take && op_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        cnt_next    = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ----- rtl/core/sdq_back.sv -----
// Back part of the searchable deque: the row of entry cells with parallel
// compare and shift, the fill count, and a two-slot result queue.
// Depends on sdq_pkg.
module sdq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_take,
    input  sdq_pkg::op_t       op,
    output logic               empty,
    input  logic               pop,
    output sdq_pkg::out_word_t result
);

    logic [sdq_pkg::VALUE_BITS-1:0] entries_reg  [sdq_pkg::DEPTH];
    logic [sdq_pkg::VALUE_BITS-1:0] entries_next [sdq_pkg::DEPTH];
    logic [sdq_pkg::LEN_BITS-1:0]   count_reg;
    logic [sdq_pkg::LEN_BITS-1:0]   count_next;

    sdq_pkg::out_word_t res_reg [2];
    logic               res_wr_ptr_reg;
    logic               res_rd_ptr_reg;
    logic [1:0]         res_cnt_reg;
    logic [1:0]         res_cnt_next;
    logic               res_rd;

    logic [sdq_pkg::DEPTH-1:0]    match;
    logic                         hit;
    logic [sdq_pkg::IDX_BITS-1:0] first_idx;
    logic [sdq_pkg::LEN_BITS-1:0] tail_len;
    logic [sdq_pkg::IDX_BITS-1:0] tail_idx;
    logic                         is_full;
    logic                         is_empty;
    logic                         add_ok;
    logic                         take_ok;
    logic                         rm_en;
    logic [sdq_pkg::IDX_BITS-1:0] rm_pos;
    sdq_pkg::out_word_t           res_word;

    assign op_take  = op_valid && (res_cnt_reg != 2'd2);
    assign is_full  = (count_reg == sdq_pkg::LEN_BITS'(sdq_pkg::DEPTH));
    assign is_empty = (count_reg == '0);
    assign tail_len = count_reg - sdq_pkg::LEN_BITS'(1);
    assign tail_idx = tail_len[sdq_pkg::IDX_BITS-1:0];
    assign add_ok   = op.add && !is_full;
    assign take_ok  = op.take && !is_empty;

    always_comb
    begin
        for (int i = 0; i < sdq_pkg::DEPTH; i++)
        begin
            match[i] = (sdq_pkg::LEN_BITS'(i) < count_reg) && (entries_reg[i] == op.value);
        end
        hit       = |match;
        first_idx = '0;
        for (int i = sdq_pkg::DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                first_idx = sdq_pkg::IDX_BITS'(i);
            end
        end
    end

    always_comb
    begin
        rm_en  = 1'b0;
        rm_pos = '0;
        if (take_ok && op.at_front)
        begin
            rm_en = 1'b1;
        end
        else if (op.remove_match && hit)
        begin
            rm_en  = 1'b1;
            rm_pos = first_idx;
        end
    end

    always_comb
    begin
        for (int i = 0; i < sdq_pkg::DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (add_ok && op.at_front)
            begin
                if (i == 0)
                begin
                    entries_next[i] = op.value;
                end
                else
                begin
                    entries_next[i] = entries_reg[i - 1];
                end
            end
            else if (add_ok && (count_reg[sdq_pkg::IDX_BITS-1:0] == sdq_pkg::IDX_BITS'(i)))
            begin
                entries_next[i] = op.value;
            end
            else if (rm_en && (sdq_pkg::IDX_BITS'(i) >= rm_pos) && (i < sdq_pkg::DEPTH - 1))
            begin
                entries_next[i] = entries_reg[i + 1];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (add_ok)
        begin
            count_next = count_reg + sdq_pkg::LEN_BITS'(1);
        end
        else if (take_ok || (op.remove_match && hit))
        begin
            count_next = tail_len;
        end
    end

    always_comb
    begin
        res_word        = '0;
        res_word.status = sdq_pkg::ST_OK;
        if (op.add && is_full)
        begin
            res_word.status = sdq_pkg::ST_FULL;
        end
        else if (op.take && is_empty)
        begin
            res_word.status = sdq_pkg::ST_EMPTY;
        end
        else if (op.search && !hit)
        begin
            res_word.status = sdq_pkg::ST_NOT_FOUND;
        end
        if (take_ok)
        begin
            if (op.at_front)
            begin
                res_word.out_value = sdq_pkg::ITEM_W'(entries_reg[0]);
            end
            else
            begin
                res_word.out_value = sdq_pkg::ITEM_W'(entries_reg[tail_idx]);
            end
        end
        if (op.search && hit)
        begin
            res_word.found_index = sdq_pkg::INDEX_W'(first_idx);
        end
        res_word.new_length = sdq_pkg::LENGTH_W'(count_next);
    end

    assign empty        = (res_cnt_reg == 2'd0);
    assign result       = res_reg[res_rd_ptr_reg];
    assign res_rd       = pop && !empty;
    assign res_cnt_next = res_cnt_reg + {1'b0, op_take} - {1'b0, res_rd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (op_take)
            begin
                count_reg <= count_next;
            end
            res_wr_ptr_reg <= res_wr_ptr_reg ^ op_take;
            res_rd_ptr_reg <= res_rd_ptr_reg ^ res_rd;
            res_cnt_reg    <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            for (int i = 0; i < sdq_pkg::DEPTH; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
            res_reg[res_wr_ptr_reg] <= res_word;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sdq_pkg::LEN_BITS'(sdq_pkg::DEPTH))
        else $error("Fill count exceeds the list depth.");

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg != 2'd3)
        else $error("Result queue holds more than two words.");

    a_res_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (op_take && !res_rd) |=> (res_cnt_reg == $past(res_cnt_reg) + 2'd1))
        else $error("Executed command did not add a result word.");

    a_add_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (op_take && add_ok) |=> (count_reg == $past(count_reg) + sdq_pkg::LEN_BITS'(1)))
        else $error("Accepted add did not grow the list.");
`endif

endmodule

// ----- rtl/core/searchable_deque.sv -----
// Top level of the searchable deque: joins the decoding front and the
// executing back through a two-slot operation queue.
// Depends on sdq_pkg, sdq_front and sdq_back.
//
// Usage: words enter as a queue. A word is taken at a rising edge where push
// is high and full is low; it carries a command and a value. Every command
// yields exactly one result word, which waits on the result port while empty
// is low and is taken at an edge where pop is high and empty is low. Results
// leave in command order.
// A taken command is registered in the front queue; from there the back
// executes it while the cell row shifts and compares all sixteen entries in
// parallel, and the result word is registered into the result queue.
// Throughput: one command per cycle while pop is held high. When the
// receiver stalls, the two-slot result queue fills, the back stops taking
// operations, the front queue fills and full rises; nothing is dropped.
// Reset clears the fill count and both queues; entry contents are left as
// they are and are never read before being written.
module searchable_deque (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  sdq_pkg::in_word_t   item,
    output logic                empty,
    input  logic                pop,
    output sdq_pkg::out_word_t  result
);

    logic         op_valid;
    logic         op_take;
    sdq_pkg::op_t op;

    sdq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .op_valid (op_valid),
        .op_take  (op_take),
        .op       (op)
    );

    sdq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_take  (op_take),
        .op       (op),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule
